/* sv/multi_waveform_sample_generator_defines.svh */
// Assertion helpers shared by the RTL.
`ifndef MULTI_WAVEFORM_SAMPLE_GENERATOR_DEFINES_SVH
`define MULTI_WAVEFORM_SAMPLE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwsg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MWSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwsg: next-cycle check failed");

`endif

/* sv/mwsg_pkg.sv */
package mwsg_pkg;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAWTOOTH = 2'd3
  } wave_shape_t;

  // Shaping controls handed from the register block to the shaper.
  typedef struct packed {
    wave_shape_t wave_shape;
    logic        wide_samples;
  } cfg_t;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_WAVE_SHAPE   = 2'd0;
  localparam logic [1:0] REG_WIDE_SAMPLES = 2'd1;
  localparam logic [1:0] REG_PHASE_STEP   = 2'd2;

  localparam wave_shape_t WAVE_SHAPE_RESET = SHAPE_SINE;
  localparam logic        WIDE_RESET       = 1'b1;
  localparam logic [31:0] PHASE_STEP_RESET = 32'd42817282;

  localparam logic [14:0] AMP_WIDE           = 15'd32767;
  localparam logic [14:0] AMP_NARROW         = 15'd127;
  localparam logic [15:0] SQUARE_HIGH_WIDE   = 16'h7FFF;
  localparam logic [15:0] SQUARE_LOW_WIDE    = 16'h8001;
  localparam logic [15:0] SQUARE_HIGH_NARROW = 16'd255;
  localparam logic [15:0] SQUARE_LOW_NARROW  = 16'd0;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TaylorDiv [1:9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

  // Quarter-wave sine entry k in Q30, integer Taylor series through x^19.
  function automatic logic [30:0] sine_entry(input int unsigned addr_bits,
                                             input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 9; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TaylorDiv[n];
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    return sum[30:0];
  endfunction

endpackage

/* sv/mwsg_phase_acc.sv */
module mwsg_phase_acc #(
  parameter int PHASE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic        restart,
  input  logic [31:0] phase_step,
  output logic [31:0] turn
);

  localparam int SumW = (PHASE_BITS > 32) ? PHASE_BITS : 32;

  logic [PHASE_BITS-1:0] acc_r;
  logic [PHASE_BITS-1:0] acc_nxt;
  logic [PHASE_BITS-1:0] cur;
  logic [SumW-1:0]       sum;
  logic [SumW-1:0]       aligned;

  // Phase of this sample: zero on restart.
  assign cur     = restart ? '0 : acc_r;
  assign sum     = SumW'(cur) + SumW'(phase_step);
  assign acc_nxt = sum[PHASE_BITS-1:0];

  // Align to a 32-bit turn fraction.
  assign aligned = SumW'(cur) << (SumW - PHASE_BITS);
  assign turn    = aligned[SumW-1 -: 32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (advance) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

/* sv/mwsg_sine_rom.sv */
module mwsg_sine_rom #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic        clk,
  input  logic        rd_en,
  input  logic [31:0] turn,
  output logic [30:0] mag_r
);

  localparam int IdxW  = SINE_ADDR_BITS + 1;
  localparam int Depth = (1 << SINE_ADDR_BITS) + 1;

  typedef logic [30:0] rom_word_t;
  typedef rom_word_t rom_t [Depth];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < Depth; k++) begin
      t[k] = mwsg_pkg::sine_entry(SINE_ADDR_BITS, k);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();
  localparam logic [IdxW-1:0] FULL_IDX = IdxW'(1) << SINE_ADDR_BITS;

  logic [SINE_ADDR_BITS-1:0] fwd;
  logic [IdxW-1:0]           idx;

  // Count backward in the second and fourth quadrants.
  assign fwd = turn[29 -: SINE_ADDR_BITS];
  assign idx = turn[30] ? (FULL_IDX - {1'b0, fwd}) : {1'b0, fwd};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mag_r <= SINE_ROM[idx];
    end
  end

endmodule

/* sv/mwsg_shaper.sv */
module mwsg_shaper (
  input  mwsg_pkg::cfg_t cfg,
  input  logic [31:0]    turn,
  input  logic [30:0]    sine_mag,
  output logic [15:0]    sample
);

  logic [1:0]  quad;
  logic [29:0] frac;
  logic [30:0] tri_down;
  logic [32:0] mag;
  logic        neg;
  logic        square;
  logic [33:0] operand;
  logic [14:0] gain;
  logic [48:0] prod;
  logic [16:0] amp;

  assign quad     = turn[31:30];
  assign frac     = turn[29:0];
  assign tri_down = mwsg_pkg::ONE_Q30 - {1'b0, frac};

  // Magnitude in Q32 and sign for each shape; square only sets the square flag.
  always_comb begin
    mag    = '0;
    neg    = 1'b0;
    square = 1'b0;
    case (cfg.wave_shape)
      mwsg_pkg::SHAPE_SINE: begin
        mag = {sine_mag, 2'b00};
        neg = quad[1];
      end
      mwsg_pkg::SHAPE_SQUARE: begin
        square = 1'b1;
      end
      mwsg_pkg::SHAPE_TRIANGLE: begin
        mag = quad[0] ? {tri_down, 2'b00} : {1'b0, frac, 2'b00};
        neg = quad[1];
      end
      mwsg_pkg::SHAPE_SAWTOOTH: begin
        if (turn[31]) begin
          mag = {1'b0, turn[30:0], 1'b0};
        end else begin
          mag = 33'h1_0000_0000 - {1'b0, turn[30:0], 1'b0};
          neg = 1'b1;
        end
      end
      default: begin
        square = 1'b1;
      end
    endcase
  end

  // One scaling multiplier serves both output widths.
  always_comb begin
    if (cfg.wide_samples) begin
      operand = {1'b0, mag};
      gain    = mwsg_pkg::AMP_WIDE;
    end else begin
      operand = neg ? (mwsg_pkg::ONE_Q32 - {1'b0, mag}) : (mwsg_pkg::ONE_Q32 + {1'b0, mag});
      gain    = mwsg_pkg::AMP_NARROW;
    end
  end

  assign prod = 49'(operand) * 49'(gain);
  assign amp  = prod[48:32];

  always_comb begin
    if (square) begin
      if (cfg.wide_samples) begin
        sample = turn[31] ? mwsg_pkg::SQUARE_LOW_WIDE : mwsg_pkg::SQUARE_HIGH_WIDE;
      end else begin
        sample = turn[31] ? mwsg_pkg::SQUARE_LOW_NARROW : mwsg_pkg::SQUARE_HIGH_NARROW;
      end
    end else if (cfg.wide_samples && neg) begin
      sample = 16'(17'd0 - amp);
    end else begin
      sample = amp[15:0];
    end
  end

endmodule

/* sv/multi_waveform_sample_generator.sv */
// Direct digital synthesis sample generator. Each transaction on the input
// channel is one sample tick; each produces exactly one transaction on the
// output channel carrying a sine, square, triangle or sawtooth sample, in
// order. in_restart clears the phase before that sample. The phase
// accumulator then advances by phase_step (units of 2^-PHASE_BITS turn).
// Throughput is one sample per clock: a tick is taken in every cycle the
// output side is not stalled. The accepting edge adds the phase and reads
// the sine ROM into the stage-1 registers; when the pipe advances, the
// sample is scaled (one 34x15 multiply) into the output register, which
// raises out_valid. The phase add and the registered ROM read set the
// throughput. The sine quarter-wave ROM has 2^SINE_ADDR_BITS+1 entries,
// built as constants at elaboration; there is no fill or clear pass after
// reset.
// Registers (APB, byte address 4*i): 0 wave_shape, 1 wide_samples,
// 2 phase_step. Write them only while no sample is in flight.
// In 16-bit mode out_sample is signed +/-32767; in 8-bit mode it is 0..255.
module multi_waveform_sample_generator #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // tick channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  // sample channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_sample,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "multi_waveform_sample_generator_defines.svh"

  // Configuration registers
  mwsg_pkg::wave_shape_t wave_shape_r;
  logic                  wide_r;
  logic [31:0]           phase_step_r;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;
  mwsg_pkg::cfg_t        cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_shape_r <= mwsg_pkg::WAVE_SHAPE_RESET;
      wide_r       <= mwsg_pkg::WIDE_RESET;
      phase_step_r <= mwsg_pkg::PHASE_STEP_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        mwsg_pkg::REG_WAVE_SHAPE:   wave_shape_r <= mwsg_pkg::wave_shape_t'(pwdata[1:0]);
        mwsg_pkg::REG_WIDE_SAMPLES: wide_r       <= pwdata[0];
        mwsg_pkg::REG_PHASE_STEP:   phase_step_r <= pwdata;
        default: begin
          // drop writes to unmapped addresses
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mwsg_pkg::REG_WAVE_SHAPE:   prdata = {30'd0, wave_shape_r};
      mwsg_pkg::REG_WIDE_SAMPLES: prdata = {31'd0, wide_r};
      mwsg_pkg::REG_PHASE_STEP:   prdata = phase_step_r;
      default:                    prdata = '0;
    endcase
  end

  assign cfg.wave_shape   = wave_shape_r;
  assign cfg.wide_samples = wide_r;

  // Pipeline control: the whole pipe advances when the output register is
  // empty or being drained; stage 1 also fills whenever it is empty.
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        advance;
  logic        in_take;
  logic [31:0] turn;
  logic [31:0] turn_r;
  logic [30:0] sine_mag_r;
  logic [15:0] shaped;
  logic [15:0] out_sample_r;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance || !s1_valid_r;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1: phase accumulator and sine ROM read
  mwsg_phase_acc #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (in_take),
    .restart    (in_restart),
    .phase_step (phase_step_r),
    .turn       (turn)
  );

  mwsg_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk   (clk),
    .rd_en (in_take),
    .turn  (turn),
    .mag_r (sine_mag_r)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      turn_r <= turn;
    end
  end

  // Stage 2: shape and scale into the output register
  mwsg_shaper u_shaper (
    .cfg      (cfg),
    .turn     (turn_r),
    .sine_mag (sine_mag_r),
    .sample   (shaped)
  );

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_sample_r <= shaped;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // A full, stalled pipe must refuse new ticks.
  `MWSG_ASSERT_NOW(a_full_stall_blocks, clk, rst_n,
    out_valid_r && !out_ready && s1_valid_r, !in_ready)
  // A pending stage-1 sample moves to the output when the pipe advances.
  `MWSG_ASSERT_NEXT(a_s1_to_out, clk, rst_n, s1_valid_r && advance, out_valid_r)
  // A restart tick is shaped at phase zero.
  `MWSG_ASSERT_NEXT(a_restart_zero, clk, rst_n, in_take && in_restart,
    s1_valid_r && (turn_r == 32'd0))

endmodule
